>>> sv/lpfa_pkg.sv
`default_nettype none

package lpfa_pkg;

    localparam int STATE_W    = 64;
    localparam int PC_W       = 31;
    localparam int REM_W      = PC_W + 1;
    localparam int ADDR_W     = 32;
    localparam int KEY_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int DIV_CNT_W  = $clog2(STATE_W);
    localparam int MOD3       = 3;
    localparam int FLIPS_PER_BYTE_DEF = 16;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_SEED  = 2'd0,
        CFG_PIXEL_COUNT = 2'd1
    } t_cfg_idx;

    // controller to datapath commands
    typedef struct packed {
        logic accept;
        logic start_div;
        logic emit;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic div_done;
        logic out_free;
        logic flip_last;
        logic pc_zero;
    } t_status;

    // one shift step: shift right, feedback into the two top bits
    function automatic logic [STATE_W-1:0] advance(input logic [STATE_W-1:0] s);
        logic [STATE_W-1:0] nxt;
        nxt = s >> 1;
        nxt[STATE_W-1] = s[1] ^ s[2];
        nxt[STATE_W-2] = s[STATE_W-1] | (s[0] ^ s[1]);
        return nxt;
    endfunction

endpackage

`default_nettype wire

>>> sv/lpfa_if.sv
`default_nettype none

// key byte channel
interface lpfa_in_if;
    import lpfa_pkg::*;
    logic               valid;
    logic               ready;
    logic [KEY_W-1:0]   key_byte;
    logic               first_byte;
    modport source(output valid, key_byte, first_byte, input ready);
    modport sink(input valid, key_byte, first_byte, output ready);
endinterface

// flip result channel
interface lpfa_out_if;
    import lpfa_pkg::*;
    logic               valid;
    logic               ready;
    logic [ADDR_W-1:0]  flip_address;
    logic               flip_mask;
    logic               last_of_byte;
    modport source(output valid, flip_address, flip_mask, last_of_byte, input ready);
    modport sink(input valid, flip_address, flip_mask, last_of_byte, output ready);
endinterface

// configuration write channel
interface lpfa_cfg_if;
    import lpfa_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [STATE_W-1:0]   data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> sv/lpfa_ctrl.sv
`default_nettype none

module lpfa_ctrl (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  lpfa_pkg::t_status  i_status,
    output lpfa_pkg::t_cmd     o_cmd
);
    import lpfa_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_DIV,
        S_EMIT
    } t_state;

    t_state r_state, n_state;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (!i_status.pc_zero) begin
                        n_state = S_START;
                    end
                end
            end
            S_START: begin
                o_cmd.start_div = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = i_status.flip_last ? S_IDLE : S_START;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

>>> sv/lpfa_dp.sv
`default_nettype none

module lpfa_dp #(
    parameter int FLIPS_PER_BYTE = lpfa_pkg::FLIPS_PER_BYTE_DEF
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  lpfa_pkg::t_cmd                i_cmd,
    output lpfa_pkg::t_status             o_status,
    input  wire [lpfa_pkg::KEY_W-1:0]     i_key_byte,
    input  wire                           i_first_byte,
    input  wire                           i_cfg_valid,
    input  wire [lpfa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire [lpfa_pkg::STATE_W-1:0]   i_cfg_data,
    output logic                          o_out_valid,
    input  wire                           i_out_ready,
    output logic [lpfa_pkg::ADDR_W-1:0]   o_flip_address,
    output logic                          o_flip_mask,
    output logic                          o_last_of_byte
);
    import lpfa_pkg::*;

    localparam int CLOG_N = $clog2(FLIPS_PER_BYTE);
    localparam int CNT_W  = (CLOG_N < 3) ? 3 : CLOG_N;
    localparam logic [CNT_W-1:0] LAST_FLIP = CNT_W'(FLIPS_PER_BYTE - 1);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(STATE_W - 1);

    logic [STATE_W-1:0]   r_seed;
    logic [PC_W-1:0]      r_pc;
    logic [STATE_W-1:0]   r_shift, n_shift;
    logic [KEY_W-1:0]     r_byte;
    logic [CNT_W-1:0]     r_flip_cnt;
    logic [STATE_W-1:0]   r_dividend;
    logic [REM_W-1:0]     r_rem, n_rem;
    logic [1:0]           r_mod3, n_mod3;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic                 r_div_busy;
    logic                 r_out_valid;
    logic [ADDR_W-1:0]    r_addr;
    logic                 r_mask;
    logic                 r_last;

    logic [REM_W-1:0]     div_trial;
    logic [2:0]           mod3_trial;
    logic                 div_bit;
    logic                 out_free;
    logic [ADDR_W-1:0]    flip_addr;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
            r_pc   <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_START_SEED:  r_seed <= i_cfg_data;
                CFG_PIXEL_COUNT: r_pc   <= i_cfg_data[PC_W-1:0];
                default: ;
            endcase
        end
    end

    // shift state update
    always_comb begin
        n_shift = r_shift;
        if (i_cmd.accept && i_first_byte) begin
            n_shift = r_seed;
        end else if (i_cmd.emit) begin
            n_shift = advance(r_shift);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= '0;
        end else begin
            r_shift <= n_shift;
        end
    end

    // key byte and flip counter
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_byte <= i_key_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flip_cnt <= '0;
        end else if (i_cmd.accept) begin
            r_flip_cnt <= '0;
        end else if (i_cmd.emit) begin
            r_flip_cnt <= r_flip_cnt + 1'b1;
        end
    end

    // restoring divider step, one dividend bit per cycle, mod 3 alongside
    always_comb begin
        div_bit    = r_dividend[STATE_W-1];
        div_trial  = {r_rem[REM_W-2:0], div_bit};
        n_rem      = div_trial;
        if (div_trial >= {1'b0, r_pc}) begin
            n_rem = div_trial - {1'b0, r_pc};
        end
        mod3_trial = {r_mod3, div_bit};
        n_mod3     = mod3_trial[1:0];
        if (mod3_trial >= 3'(MOD3)) begin
            n_mod3 = 2'(mod3_trial - 3'(MOD3));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_busy <= 1'b0;
            r_div_cnt  <= '0;
        end else if (i_cmd.start_div) begin
            r_div_busy <= 1'b1;
            r_div_cnt  <= '0;
        end else if (r_div_busy) begin
            r_div_cnt <= r_div_cnt + 1'b1;
            if (r_div_cnt == DIV_LAST) begin
                r_div_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_div) begin
            r_dividend <= r_shift;
            r_rem      <= '0;
            r_mod3     <= '0;
        end else if (r_div_busy) begin
            r_dividend <= r_dividend << 1;
            r_rem      <= n_rem;
            r_mod3     <= n_mod3;
        end
    end

    // address: four bytes per pixel plus channel, wraps at 32 bits
    assign flip_addr = {r_rem[ADDR_W-3:0], 2'b00} + ADDR_W'(r_mod3);

    // output register
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_addr <= flip_addr;
            r_mask <= r_byte[r_flip_cnt[2:0]];
            r_last <= (r_flip_cnt == LAST_FLIP);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_flip_address = r_addr;
    assign o_flip_mask    = r_mask;
    assign o_last_of_byte = r_last;

    assign o_status.div_done  = r_div_busy && (r_div_cnt == DIV_LAST);
    assign o_status.out_free  = out_free;
    assign o_status.flip_last = (r_flip_cnt == LAST_FLIP);
    assign o_status.pc_zero   = (r_pc == '0);

    // divider finishes after its last bit
    a_div_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.div_done |=> !r_div_busy)
        else $error("divider still busy after last step");

    // remainder ends below the pixel count
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_div_busy) |-> (r_rem < {1'b0, r_pc}))
        else $error("remainder not below pixel count");

    // no result is produced while a division runs
    a_emit_idle_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> !r_div_busy && !i_cmd.start_div)
        else $error("result emitted during division");

    // an emitted word never overwrites one still pending
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !i_cmd.emit)
        else $error("pending result overwritten");

endmodule

`default_nettype wire

>>> sv/lfsr_pixel_flip_address_generator_unit.sv
// each result word takes a start step, a 64-step bit-serial modulo and an emit step;
//   the emit waits while the output register still holds an unaccepted word, and the next
//   key byte is taken only after the last result word of the current byte is emitted
// a byte arriving with pixel count zero is accepted and yields nothing
// reset (synchronous, active low) clears the shift state, seed, pixel count and all control
`default_nettype none

module lfsr_pixel_flip_address_generator_unit #(
    parameter int FLIPS_PER_BYTE = lpfa_pkg::FLIPS_PER_BYTE_DEF
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    lpfa_in_if.sink      i_in,
    lpfa_out_if.source   o_out,
    lpfa_cfg_if.sink     i_cfg
);
    import lpfa_pkg::*;

    t_cmd    cmd;
    t_status status;

    // configuration writes always taken
    assign i_cfg.ready = 1'b1;

    lpfa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    lpfa_dp #(
        .FLIPS_PER_BYTE (FLIPS_PER_BYTE)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_key_byte     (i_in.key_byte),
        .i_first_byte   (i_in.first_byte),
        .i_cfg_valid    (i_cfg.valid),
        .i_cfg_index    (i_cfg.index),
        .i_cfg_data     (i_cfg.data),
        .o_out_valid    (o_out.valid),
        .i_out_ready    (o_out.ready),
        .o_flip_address (o_out.flip_address),
        .o_flip_mask    (o_out.flip_mask),
        .o_last_of_byte (o_out.last_of_byte)
    );

endmodule

`default_nettype wire

>>> tb/lfsr_pixel_flip_address_generator_unit_test.sv
`default_nettype none

module lfsr_pixel_flip_address_generator_unit_test;
    import lpfa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int      FLIPS         = FLIPS_PER_BYTE_DEF;
    localparam int      KEY_LEN       = 32;
    localparam int      DRAIN_CYCLES  = 100;
    localparam longint  CYCLE_LIMIT   = 3_000_000;
    localparam int      PHASE_ITEMS   = 120;

    // register indexes past the end of the list, writes must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 2'd3;

    typedef struct packed {
        logic [ADDR_W-1:0] flip_address;
        logic              flip_mask;
        logic              last_of_byte;
    } t_flip_word;

    // flip address predictor and store of expected flip words
    class flip_scoreboard;
        logic [STATE_W-1:0] seed;
        logic [PC_W-1:0]    pixels;
        logic [STATE_W-1:0] shift_reg;
        t_flip_word         pending_flips[$];
        int                 errors;

        function new();
            seed      = '0;
            pixels    = '0;
            shift_reg = '0;
            errors    = 0;
        endfunction

        // shift right, s[1]^s[2] into the top bit, s[0]^s[1] or-ed into the next one
        function logic [STATE_W-1:0] next_shift_state(logic [STATE_W-1:0] s);
            logic [STATE_W-1:0] n;
            n = s >> 1;
            n[63] = n[63] | (s[1] ^ s[2]);
            n[62] = n[62] | (s[0] ^ s[1]);
            return n;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [STATE_W-1:0] data);
            if (idx == CFG_START_SEED)
                seed = data;
            else if (idx == CFG_PIXEL_COUNT)
                pixels = data[PC_W-1:0];
        endfunction

        // accepted key byte: predict its flip words
        function void note_byte(logic [KEY_W-1:0] key, logic first);
            t_flip_word         w;
            logic [STATE_W-1:0] s;
            logic [STATE_W-1:0] addr;
            logic [STATE_W-1:0] pc_wide;
            if (first)
                shift_reg = seed;
            if (pixels == '0)
                return;
            pc_wide = {{(STATE_W-PC_W){1'b0}}, pixels};
            for (int j = 0; j < FLIPS; j++) begin
                s    = shift_reg;
                addr = 64'd4 * (s % pc_wide) + (s % 64'd3);
                w.flip_address = addr[ADDR_W-1:0];
                w.flip_mask    = key[j % 8];
                w.last_of_byte = (j == FLIPS - 1);
                pending_flips.push_back(w);
                shift_reg = next_shift_state(s);
            end
        endfunction

        // accepted flip word against the oldest prediction
        function void check_flip(logic [ADDR_W-1:0] addr, logic mask, logic last);
            t_flip_word w;
            if (pending_flips.size() == 0) begin
                errors++;
                $display("%0t: unexpected flip word addr=%h mask=%b last=%b",
                         $time, addr, mask, last);
                return;
            end
            w = pending_flips.pop_front();
            if (addr !== w.flip_address) begin
                errors++;
                $display("%0t: flip_address expected %h actual %h",
                         $time, w.flip_address, addr);
            end
            if (mask !== w.flip_mask) begin
                errors++;
                $display("%0t: flip_mask expected %b actual %b", $time, w.flip_mask, mask);
            end
            if (last !== w.last_of_byte) begin
                errors++;
                $display("%0t: last_of_byte expected %b actual %b",
                         $time, w.last_of_byte, last);
            end
        endfunction

        function int pending();
            return pending_flips.size();
        endfunction
    endclass

    logic   i_clk = 1'b0;
    logic   i_rst_n;
    bit     gaps_on;
    longint cycle_count;
    int     items_sent;

    flip_scoreboard sb;

    lpfa_in_if  key_if();
    lpfa_out_if flip_if();
    lpfa_cfg_if cfg_if();

    lfsr_pixel_flip_address_generator_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (key_if),
        .o_out   (flip_if),
        .i_cfg   (cfg_if)
    );

    // clock
    always #4 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // flip word monitor
    always @(posedge i_clk) begin
        if (i_rst_n && flip_if.valid && flip_if.ready)
            sb.check_flip(flip_if.flip_address, flip_if.flip_mask, flip_if.last_of_byte);
    end

    // receiver backpressure in random bursts
    initial begin
        flip_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (gaps_on && $urandom_range(0, 11) == 0) begin
                flip_if.ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
            flip_if.ready <= 1'b1;
        end
    end

    // one key byte word, with an optional gap ahead of it
    task automatic send_byte(logic [KEY_W-1:0] key, logic first);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            key_if.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        key_if.valid      <= 1'b1;
        key_if.key_byte   <= key;
        key_if.first_byte <= first;
        do @(posedge i_clk); while (!key_if.ready);
        sb.note_byte(key, first);
        items_sent++;
    endtask

    // hold the sender until every predicted flip word has arrived
    task automatic drain();
        key_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // one register write word, only while idle
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [STATE_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        sb.write_reg(idx, data);
    endtask

    // a whole key, or a broken run with random first flags
    task automatic send_key(bit well_formed);
        int len;
        len = well_formed ? KEY_LEN : $urandom_range(1, KEY_LEN - 1);
        for (int i = 0; i < len; i++)
            send_byte(8'($urandom_range(0, 255)),
                      well_formed ? (i == 0) : ($urandom_range(0, 7) == 0));
    endtask

    task automatic random_phase(logic [STATE_W-1:0] seed_val, logic [STATE_W-1:0] pc_val);
        int  start;
        bit  paused;
        drain();
        write_reg(CFG_START_SEED, seed_val);
        write_reg(CFG_PIXEL_COUNT, pc_val);
        start  = items_sent;
        paused = 1'b0;
        while (items_sent - start < PHASE_ITEMS) begin
            send_key($urandom_range(0, 4) != 0);
            if (!paused && items_sent - start >= PHASE_ITEMS / 2) begin
                key_if.valid <= 1'b0;
                while (sb.pending() != 0) @(posedge i_clk);
                paused = 1'b1;
            end
        end
    endtask

    initial begin
        logic [STATE_W-1:0] held_seed;

        sb          = new();
        gaps_on     = 1'b1;
        cycle_count = 0;
        items_sent  = 0;

        // known values on every input before the first edge
        i_rst_n           <= 1'b0;
        key_if.valid      <= 1'b0;
        key_if.key_byte   <= '0;
        key_if.first_byte <= 1'b0;
        cfg_if.valid      <= 1'b0;
        cfg_if.index      <= CFG_START_SEED;
        cfg_if.data       <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // pixel count still zero after reset: bytes are swallowed
        send_byte(8'h5A, 1'b1);
        send_byte(8'hC3, 1'b0);
        drain();

        // writes past the register list are dropped
        write_reg(CFG_IDX_SPARE_LO, {$urandom, $urandom});
        write_reg(CFG_IDX_SPARE_HI, {$urandom, $urandom});

        // single pixel, all-ones seed
        write_reg(CFG_START_SEED, '1);
        write_reg(CFG_PIXEL_COUNT, 64'd1);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hA5, 1'b1);
        drain();

        // largest pixel count, address wraps to 32 bits
        write_reg(CFG_START_SEED, {$urandom, $urandom});
        write_reg(CFG_PIXEL_COUNT, 64'h0000_0000_7FFF_FFFF);
        send_byte(8'h80, 1'b1);
        send_byte(8'h01, 1'b0);
        drain();

        // pixel count of 2^30, half of its range
        write_reg(CFG_PIXEL_COUNT, 64'd1073741824);
        send_byte(8'($urandom_range(0, 255)), 1'b1);
        drain();

        // upper data bits masked off the pixel count, zero seed stays zero
        write_reg(CFG_PIXEL_COUNT, 64'hFFFF_FFFF_8000_0003);
        write_reg(CFG_START_SEED, '0);
        send_byte(8'hFF, 1'b1);
        drain();
        write_reg(CFG_START_SEED, 64'd1);
        send_byte(8'h55, 1'b1);
        drain();

        // reload under zero pixel count still lands in the shift state
        held_seed = {$urandom, $urandom};
        write_reg(CFG_START_SEED, held_seed);
        write_reg(CFG_PIXEL_COUNT, 64'd0);
        send_byte(8'h12, 1'b1);
        drain();
        write_reg(CFG_START_SEED, ~held_seed);
        write_reg(CFG_PIXEL_COUNT, 64'd7);
        send_byte(8'h34, 1'b0);
        drain();
        write_reg(CFG_IDX_SPARE_LO, {$urandom, $urandom});
        write_reg(CFG_IDX_SPARE_HI, {$urandom, $urandom});
        send_byte(8'h66, 1'b0);

        // random phases across small, mid and large pixel counts
        random_phase({$urandom, $urandom}, 64'($urandom_range(1, 16)));
        random_phase({$urandom, $urandom}, 64'($urandom_range(1, 1073741824)));

        // zero pixel count, bytes ignored
        drain();
        write_reg(CFG_PIXEL_COUNT, 64'd0);
        for (int i = 0; i < 16; i++)
            send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

        random_phase({$urandom, $urandom},
                     {$urandom, 1'b0, 31'($urandom_range(32'h4000_0000, 32'h7FFF_FFFF))});

        // last phase without random gaps on either side
        drain();
        gaps_on = 1'b0;
        random_phase({$urandom, $urandom}, 64'($urandom_range(1, 1000)));

        // wait out the remaining flip words
        key_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
